// ----- rtl/core/olte_pkg.sv -----
// Shared types, codes and defaults for the ordered list table engine.
`timescale 1ns / 1ps

package olte_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int WORD_WIDTH_DEFAULT = 32;

  // Beat field widths.
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int HIDX_W = 4;
  localparam int CNT_W  = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd6;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic load;         // take the broadcast word
    logic take_left;    // take the lower neighbor's entry
    logic take_right;   // take the upper neighbor's entry
    logic compare;      // capture the match of the entry against the key
    logic shift_match;  // take the upper neighbor's match bit
  } cell_ctrl_t;

endpackage

// ----- rtl/core/olte_req_if.sv -----
// Request channel: operation, position and value with valid/ready.
`timescale 1ns / 1ps

interface olte_req_if;
  import olte_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

// ----- rtl/core/olte_rsp_if.sv -----
// Response channel: status, find result and entry count with valid/ready.
`timescale 1ns / 1ps

interface olte_rsp_if;
  import olte_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic              hit;
  logic [HIDX_W-1:0] hit_index;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output status, output hit, output hit_index,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input hit, input hit_index,
                  input entry_count, output ready);
endinterface

// ----- rtl/core/ordered_list_table_engine.sv -----
// Top level: ordered list held in a row of cells, with request and response channels.
//
// Each request beat on req carries one operation on the list; each produces exactly
// one response beat on rsp with status, hit flag, hit index and the entry count after
// the operation. Pushes, pop front, insert and delete load or shift the cells at and
// above the target slot in the cycle the request is taken, and pop back only lowers
// the count: a new request is taken every cycle while the receiver keeps up, and the
// response shows the cycle after. Find captures a compare result in every cell in the
// cycle it is taken, then walks the match bits down the cell row toward slot 0, one
// slot per cycle, until a hit or the count is reached; no request is taken meanwhile.
// Responses sit in an output register; a request is taken only when that register is
// empty or is being emptied in the same cycle, so a stalled receiver stalls req.
// Reset empties the list and drops any pending response. Entry contents are not
// cleared; only slots below the count are ever read.
`timescale 1ns / 1ps

module ordered_list_table_engine #(
  parameter int DEPTH      = olte_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = olte_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  olte_req_if.sink  req,
  olte_rsp_if.source rsp
);
  import olte_pkg::*;

  localparam int NUM_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ((NUM_W > POS_W) ? NUM_W : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [NUM_W-1:0]    count;
  logic [NUM_W-1:0]    count_next;
  logic [NUM_W-1:0]    scan_idx;

  logic                rsp_valid;
  logic [ST_W-1:0]     rsp_status;
  logic                rsp_hit;
  logic [HIDX_W-1:0]   rsp_hit_index;
  logic [CNT_W-1:0]    rsp_entry_count;

  logic                accept;
  logic                full;
  logic                empty;
  logic signed [63:0]  value_ext;
  logic [WORD_WIDTH-1:0] word_in;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CMP_W-1:0]    pos_m1;
  logic                ins_pos_ok;
  logic                del_pos_ok;

  logic                do_ins;
  logic                do_del;
  logic                do_drop;
  logic                do_find;
  logic [IDX_W-1:0]    slot;
  logic [ST_W-1:0]     status_c;

  logic                scan_miss;
  logic                scan_hit;
  logic                scan_step;

  cell_ctrl_t            ctrl       [DEPTH];
  logic [WORD_WIDTH-1:0] entries    [DEPTH];
  logic                  match_bits [DEPTH];

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);

  assign full  = (count == NUM_W'(DEPTH));
  assign empty = (count == '0);

  assign value_ext = 64'(req.value);
  assign word_in   = value_ext[WORD_WIDTH-1:0];

  assign pos_ext    = CMP_W'(req.position);
  assign cnt_ext    = CMP_W'(count);
  assign pos_m1     = pos_ext - CMP_W'(1);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);

  // Decode the request into a row operation and a status.
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_drop  = 1'b0;
    do_find  = 1'b0;
    slot     = '0;
    status_c = ST_DONE;
    case (req.operation)
      OP_PUSH_BACK: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          do_ins = 1'b1;
          slot   = count[IDX_W-1:0];
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          do_drop = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          do_del = 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_c = ST_FULL;
        end else if (!ins_pos_ok) begin
          status_c = ST_RANGE;
        end else begin
          do_ins = 1'b1;
          slot   = pos_m1[IDX_W-1:0];
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else if (!del_pos_ok) begin
          status_c = ST_RANGE;
        end else begin
          do_del = 1'b1;
          slot   = pos_m1[IDX_W-1:0];
        end
      end
      OP_FIND: begin
        do_find = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (accept && do_ins) begin
      count_next = count + NUM_W'(1);
    end else if (accept && (do_del || do_drop)) begin
      count_next = count - NUM_W'(1);
    end
  end

  // Match bits beyond the count are stale, so the count check comes first.
  assign scan_miss = (state == S_SCAN) && (scan_idx == count);
  assign scan_hit  = (state == S_SCAN) && !scan_miss && match_bits[0];
  assign scan_step = (state == S_SCAN) && !scan_miss && !match_bits[0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && do_find) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_miss || scan_hit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((accept && !do_find) || scan_miss || scan_hit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx <= '0;
    end else if (scan_step) begin
      scan_idx <= scan_idx + NUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !do_find) begin
      rsp_status      <= status_c;
      rsp_hit         <= 1'b0;
      rsp_hit_index   <= '0;
      rsp_entry_count <= CNT_W'(count_next);
    end else if (scan_miss || scan_hit) begin
      rsp_status      <= ST_DONE;
      rsp_hit         <= scan_hit;
      rsp_hit_index   <= scan_hit ? HIDX_W'(scan_idx) : '0;
      rsp_entry_count <= CNT_W'(count);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.hit         = rsp_hit;
  assign rsp.hit_index   = rsp_hit_index;
  assign rsp.entry_count = rsp_entry_count;

  // Row of cells; cells above the slot move up on insert, at or above it move down on delete.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_entry;
    logic [WORD_WIDTH-1:0] right_entry;
    logic                  right_match;

    always_comb begin
      ctrl[i].load        = accept && do_ins && (IDX_W'(i) == slot);
      ctrl[i].take_left   = accept && do_ins && (IDX_W'(i) > slot);
      ctrl[i].take_right  = accept && do_del && (IDX_W'(i) >= slot);
      ctrl[i].compare     = accept && do_find;
      ctrl[i].shift_match = scan_step;
    end

    if (i == 0) begin : g_first
      assign left_entry = word_in;
    end else begin : g_mid_lo
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
      assign right_match = 1'b0;
    end else begin : g_mid_hi
      assign right_entry = entries[i+1];
      assign right_match = match_bits[i+1];
    end

    olte_cell #(
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .word_in     (word_in),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .right_match (right_match),
      .entry       (entries[i]),
      .match       (match_bits[i])
    );
  end

endmodule

// ----- rtl/core/olte_cell.sv -----
// One list slot: an entry register and a match bit, linked to both neighbors.
`timescale 1ns / 1ps

module olte_cell #(
  parameter int WORD_WIDTH = olte_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  olte_pkg::cell_ctrl_t  ctrl,
  input  logic [WORD_WIDTH-1:0] word_in,
  input  logic [WORD_WIDTH-1:0] left_entry,
  input  logic [WORD_WIDTH-1:0] right_entry,
  input  logic                  right_match,
  output logic [WORD_WIDTH-1:0] entry,
  output logic                  match
);
  import olte_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= word_in;
    end else if (ctrl.take_left) begin
      entry <= left_entry;
    end else if (ctrl.take_right) begin
      entry <= right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= (entry == word_in);
    end else if (ctrl.shift_match) begin
      match <= right_match;
    end
  end

endmodule

// ----- rtl/core/olte_checker.sv -----
// Port-level checks for the ordered list table engine, bound to the top level.
`timescale 1ns / 1ps

module olte_checker #(
  parameter int DEPTH = olte_pkg::DEPTH_DEFAULT
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [olte_pkg::ST_W-1:0]   rsp_status,
  input logic                      rsp_hit,
  input logic [olte_pkg::HIDX_W-1:0] rsp_hit_index,
  input logic [olte_pkg::CNT_W-1:0]  rsp_entry_count
);
  import olte_pkg::*;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  // A response beat stays up until the receiver takes it.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  // Only a successful find can report a hit.
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_DONE) |-> !rsp_hit)
    else $error("hit flagged on a failed request");

  // Without a hit the index reads zero.
  a_hit_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> (rsp_hit_index == '0))
    else $error("hit index set without a hit");

  // Full and empty errors report the matching count.
  a_err_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp_status == ST_FULL) || (rsp_status == ST_EMPTY)) |->
      ((rsp_status == ST_FULL) ? (rsp_entry_count == FULL_COUNT)
                               : (rsp_entry_count == '0)))
    else $error("error status disagrees with entry count");

endmodule

bind ordered_list_table_engine olte_checker #(
  .DEPTH (DEPTH)
) u_olte_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_hit         (rsp.hit),
  .rsp_hit_index   (rsp.hit_index),
  .rsp_entry_count (rsp.entry_count)
);
